// ===== design/top_k_score_keeper_core_assert.svh =====
// Assertion macros shared by the top-k score keeper modules.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef TOP_K_SCORE_KEEPER_CORE_ASSERT_SVH
`define TOP_K_SCORE_KEEPER_CORE_ASSERT_SVH

// Property checked on every rising clock edge outside reset.
`define TKSK_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Condition that must never hold outside reset.
`define TKSK_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

// ===== design/tksk_pkg.sv =====
// Package of the top-k score keeper: sizes, word types and the queue item.
// Used by the channel interfaces and by every module of the block.
package tksk_pkg;

  localparam int unsigned MAX_K       = 16;
  localparam int unsigned SCORE_BITS  = 32;
  localparam int unsigned ID_BITS     = 16;
  localparam int unsigned K_BITS      = 5;
  localparam int unsigned IDX_BITS    = (MAX_K > 1) ? $clog2(MAX_K) : 1;
  localparam int unsigned CNT_BITS    = $clog2(MAX_K + 1);
  localparam int unsigned KW_BITS     = (K_BITS > CNT_BITS) ? K_BITS : CNT_BITS;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);
  localparam logic [K_BITS-1:0] K_RESET = K_BITS'(16);

  typedef logic signed [SCORE_BITS-1:0] score_t;
  typedef logic [ID_BITS-1:0]           id_t;
  typedef logic [K_BITS-1:0]            k_t;
  typedef logic [CNT_BITS-1:0]          cnt_t;
  typedef logic [IDX_BITS-1:0]          idx_t;

  // Offer as classified by the front: keep is set for a positive score.
  typedef struct packed {
    score_t score;
    id_t    id;
    logic   eoq;
    logic   keep;
  } offer_t;

  typedef struct packed {
    score_t threshold;
    id_t    entry_id;
    score_t entry_score;
    logic   entry_valid;
    logic   last;
  } result_t;

endpackage

// ===== design/tksk_if.sv =====
// Valid/ready channel interfaces of the top-k score keeper.
// Depends on tksk_pkg for the word types.
interface tksk_offer_if;
  import tksk_pkg::*;

  logic   valid;
  logic   ready;
  score_t offer_score;
  id_t    offer_id;
  logic   end_of_query;

  modport source (output valid, offer_score, offer_id, end_of_query, input ready);
  modport sink   (input valid, offer_score, offer_id, end_of_query, output ready);
endinterface

interface tksk_result_if;
  import tksk_pkg::*;

  logic   valid;
  logic   ready;
  score_t threshold;
  id_t    entry_id;
  score_t entry_score;
  logic   entry_valid;
  logic   last;

  modport source (output valid, threshold, entry_id, entry_score, entry_valid, last,
                  input ready);
  modport sink   (input valid, threshold, entry_id, entry_score, entry_valid, last,
                  output ready);
endinterface

// ===== design/tksk_front.sv =====
// Front of the top-k score keeper: accepts offer words, classifies them
// and holds them in a short queue for the list engine. Uses tksk_pkg, tksk_if.
`include "top_k_score_keeper_core_assert.svh"

module tksk_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  tksk_offer_if.sink       offer_i,
  output tksk_pkg::offer_t item_o,
  output logic             item_valid_o,
  input  logic             item_pop_i
);
  import tksk_pkg::*;

  offer_t               mem_q [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_BITS-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_BITS-1:0] cnt_q, cnt_d;
  logic                 accept;
  offer_t               incoming;

  assign offer_i.ready = (cnt_q != QCNT_BITS'(QUEUE_DEPTH));
  assign accept        = offer_i.valid && offer_i.ready;

  // Classify: only a strictly positive score can enter the list.
  always_comb begin
    incoming.score = offer_i.offer_score;
    incoming.id    = offer_i.offer_id;
    incoming.eoq   = offer_i.end_of_query;
    incoming.keep  = !offer_i.offer_score[SCORE_BITS-1] && (offer_i.offer_score != '0);
  end

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (accept) begin
      wr_ptr_d = (wr_ptr_q == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (item_pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (accept && !item_pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!accept && item_pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mem_q[wr_ptr_q] <= incoming;
    end
  end

  assign item_o       = mem_q[rd_ptr_q];
  assign item_valid_o = (cnt_q != '0);

  `TKSK_ASSERT_NEVER(a_pop_empty, item_pop_i && (cnt_q == '0), "queue popped while empty")
  `TKSK_ASSERT(a_fill_grows, (accept && !item_pop_i) |=> (cnt_q == $past(cnt_q) + 1'b1), "queue count lost a word")

endmodule

// ===== design/tksk_back.sv =====
// List engine of the top-k score keeper: sorted shift list, threshold and
// result output register. Uses tksk_pkg and tksk_result_if.
`include "top_k_score_keeper_core_assert.svh"

module tksk_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  tksk_pkg::k_t     cfg_wdata_i,
  input  tksk_pkg::offer_t item_i,
  input  logic             item_valid_i,
  output logic             item_pop_o,
  tksk_result_if.source    result_o
);
  import tksk_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_THR  = 2'd1;
  localparam logic [1:0] ST_LIST = 2'd2;

  logic [1:0]  state_q, state_d;
  k_t          k_q;
  cnt_t        cnt_q, cnt_d;
  cnt_t        rem_q, rem_d;
  logic        eoq_q, eoq_d;
  logic        res_valid_q, res_valid_d;
  result_t     res_q, res_d;
  score_t      kth_q, kth_d;
  score_t      score_q [MAX_K];
  id_t         id_q    [MAX_K];
  score_t      src_s   [MAX_K];
  id_t         src_id  [MAX_K];

  logic [KW_BITS-1:0] k_wide;
  cnt_t        keff;
  idx_t        keff_idx;
  cnt_t        cnt_eff;
  logic [MAX_K-1:0] ge;
  logic        room;
  logic        do_ins;
  logic        out_free;
  logic        res_load;
  logic        list_shift;
  score_t      thr;

  // Clamp k to 1..MAX_K.
  assign k_wide   = KW_BITS'(k_q);
  always_comb begin
    priority if (k_wide == '0) begin
      keff = CNT_BITS'(1);
    end else if (k_wide > KW_BITS'(MAX_K)) begin
      keff = CNT_BITS'(MAX_K);
    end else begin
      keff = CNT_BITS'(k_wide);
    end
  end
  assign keff_idx = IDX_BITS'(keff - 1'b1);
  assign cnt_eff  = (cnt_q > keff) ? keff : cnt_q;

  // ge marks held entries that stay ahead of the offer; it is a prefix.
  always_comb begin
    for (int i = 0; i < MAX_K; i++) begin
      ge[i] = (CNT_BITS'(i) < cnt_eff) && ($signed(score_q[i]) >= $signed(item_i.score));
    end
  end

  for (genvar gi = 0; gi < MAX_K; gi++) begin : g_src
    if (gi == 0) begin : g_head
      assign src_s[gi]  = item_i.score;
      assign src_id[gi] = item_i.id;
    end else begin : g_body
      assign src_s[gi]  = ge[gi-1] ? item_i.score : score_q[gi-1];
      assign src_id[gi] = ge[gi-1] ? item_i.id    : id_q[gi-1];
    end
  end

  assign room       = (cnt_eff < keff);
  assign do_ins     = item_i.keep && (room || !ge[keff_idx]);
  assign item_pop_o = (state_q == ST_IDLE) && item_valid_i;
  assign out_free   = !res_valid_q || result_o.ready;
  assign thr        = (cnt_q >= keff) ? score_q[keff_idx] : '0;
  assign list_shift = (state_q == ST_LIST) && out_free;

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    rem_d    = rem_q;
    eoq_d    = eoq_q;
    kth_d    = kth_q;
    res_d    = res_q;
    res_load = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (item_valid_i) begin
          cnt_d   = (do_ins && room) ? cnt_eff + 1'b1 : cnt_eff;
          eoq_d   = item_i.eoq;
          state_d = ST_THR;
        end
      end
      ST_THR: begin
        if (!eoq_q || (cnt_q == '0)) begin
          // One word carries only the threshold.
          if (out_free) begin
            res_load          = 1'b1;
            res_d.threshold   = thr;
            res_d.entry_id    = '0;
            res_d.entry_score = '0;
            res_d.entry_valid = 1'b0;
            res_d.last        = 1'b1;
            if (eoq_q) begin
              cnt_d = '0;
            end
            state_d = ST_IDLE;
          end
        end else begin
          kth_d   = thr;
          rem_d   = cnt_q;
          state_d = ST_LIST;
        end
      end
      ST_LIST: begin
        if (out_free) begin
          res_load          = 1'b1;
          res_d.threshold   = kth_q;
          res_d.entry_id    = id_q[0];
          res_d.entry_score = score_q[0];
          res_d.entry_valid = 1'b1;
          res_d.last        = (rem_q == CNT_BITS'(1));
          rem_d             = rem_q - 1'b1;
          if (rem_q == CNT_BITS'(1)) begin
            cnt_d   = '0;
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign res_valid_d = res_load ? 1'b1 : (result_o.ready ? 1'b0 : res_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      k_q         <= K_RESET;
      cnt_q       <= '0;
      rem_q       <= '0;
      eoq_q       <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      rem_q       <= rem_d;
      eoq_q       <= eoq_d;
      res_valid_q <= res_valid_d;
      if (cfg_we_i) begin
        k_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    kth_q <= kth_d;
  end

  // Insert shifts the tail down one slot; listing shifts the head out.
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MAX_K; i++) begin
      if (item_pop_o && do_ins && !ge[i]) begin
        score_q[i] <= src_s[i];
        id_q[i]    <= src_id[i];
      end else if (list_shift && (i < MAX_K - 1)) begin
        score_q[i] <= score_q[(i + 1) % MAX_K];
        id_q[i]    <= id_q[(i + 1) % MAX_K];
      end
    end
  end

  assign result_o.valid       = res_valid_q;
  assign result_o.threshold   = res_q.threshold;
  assign result_o.entry_id    = res_q.entry_id;
  assign result_o.entry_score = res_q.entry_score;
  assign result_o.entry_valid = res_q.entry_valid;
  assign result_o.last        = res_q.last;

  `TKSK_ASSERT_NEVER(a_cnt_range, cnt_q > CNT_BITS'(MAX_K), "held count above capacity")
  `TKSK_ASSERT_NEVER(a_list_rem, (state_q == ST_LIST) && (rem_q == '0), "listing with nothing left")
  `TKSK_ASSERT(a_list_end, (list_shift && (rem_q == CNT_BITS'(1))) |=> ((state_q == ST_IDLE) && (cnt_q == '0)), "list not cleared after final entry")

endmodule

// ===== design/top_k_score_keeper_core.sv =====
// Top level of the top-k score keeper core.
// Depends on tksk_pkg, tksk_if, tksk_front and tksk_back.

// Keeps the k best (score, id) offers of one query in a list sorted by
// descending score, ties in arrival order. Every offer returns one word with
// the current threshold (the k-th score once k entries are held, 0 before);
// an offer with end_of_query set and a non-empty list instead returns one
// word per held entry, best first, last set on the final one, and then clears
// the list. Scores are signed Q16.16; a score of zero or below never enters
// the list. k is set through cfg_we_i / cfg_wdata_i (0 acts as 1, values
// above 16 act as 16) and must only change while no offer is in flight.
// In the list engine an offer that yields a single word is an insert, then
// a threshold and output register load that waits while the output is
// stalled; an end-of-query offer is an insert, a threshold capture, then one
// listing step per held entry. The sorted shift list inserts in one step;
// the engine takes the next offer only once the last one is done. A two-word
// queue in front keeps taking offers until full while the engine works or
// the output is stalled, and the output register lets the engine move on
// while a finished word waits to be taken. No clearing pass after reset.
module top_k_score_keeper_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  tksk_pkg::k_t  cfg_wdata_i,
  tksk_offer_if.sink    offer_i,
  tksk_result_if.source result_o
);
  import tksk_pkg::*;

  // Queue head between front and engine.
  offer_t item;
  logic   item_valid;
  logic   item_pop;

  // Accept and classify offers, buffer them.
  tksk_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .offer_i      (offer_i),
    .item_o       (item),
    .item_valid_o (item_valid),
    .item_pop_i   (item_pop)
  );

  // Maintain the sorted list and drive result words.
  tksk_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .item_i       (item),
    .item_valid_i (item_valid),
    .item_pop_o   (item_pop),
    .result_o     (result_o)
  );

endmodule
